// File: design/cole_pkg.sv
package cole_pkg;

   // field widths of the command and response transfers
   localparam int KIND_WIDTH  = 3;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 6;

   // command codes
   localparam logic [KIND_WIDTH-1:0] KIND_START   = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_ADVANCE = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_INSERT  = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_ATTACH  = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_REMOVE  = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture the incoming command
      logic exec;    // apply it to cells, count and cursor
      logic fetch;   // load the response register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // response register can take a new result this cycle
   } dp_status_type;

endpackage

// File: design/cole_if.sv
interface cole_req_if import cole_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_WIDTH-1:0]  kind;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cole_rsp_if import cole_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] item_count;
   logic                   has_current;
   logic [VALUE_WIDTH-1:0] current_value;
   logic                   error;

   modport source (output valid, output item_count, output has_current,
                   output current_value, output error, input ready);
   modport sink   (input valid, input item_count, input has_current,
                   input current_value, input error, output ready);
endinterface

// File: design/cole_ctrl.sv
module cole_ctrl import cole_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_FETCH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            // result goes out; the next command may be taken in the same cycle
            if (status.out_free) begin
               cmd.fetch = 1'b1;
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/cole_dp.sv
module cole_dp import cole_pkg::*; #(
   parameter int CAPACITY   = 32,
   parameter int ITEM_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  logic [KIND_WIDTH-1:0]  req_kind,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COUNT_WIDTH-1:0] rsp_item_count,
   output logic                   rsp_has_current,
   output logic [VALUE_WIDTH-1:0] rsp_current_value,
   output logic                   rsp_error
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [ITEM_WIDTH-1:0]  cells_ff [CAPACITY];
   logic [KIND_WIDTH-1:0]  kind_ff;
   logic [ITEM_WIDTH-1:0]  word_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          cursor_ff, cursor_in;
   logic                   err_ff, err_in;
   logic                   out_valid_ff;
   logic [COUNT_WIDTH-1:0] out_count_ff;
   logic                   out_has_ff;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic                   out_err_ff;

   logic                   cur;
   logic                   full;
   logic                   do_ins;
   logic                   do_rem;
   logic [CW-1:0]          pos;
   logic [ITEM_WIDTH+VALUE_WIDTH-1:0] word_ext;
   logic [ITEM_WIDTH-1:0]  cell_rd;
   logic [ITEM_WIDTH+VALUE_WIDTH-1:0] cell_ext;
   logic [CW+COUNT_WIDTH-1:0] count_ext;

   assign word_ext  = {{ITEM_WIDTH{1'b0}}, req_value};
   assign cur       = cursor_ff < count_ff;
   assign full      = count_ff >= CAP_C;
   assign cell_rd   = cells_ff[cursor_ff[AW-1:0]];
   assign cell_ext  = {{VALUE_WIDTH{1'b0}}, cell_rd};
   assign count_ext = {{COUNT_WIDTH{1'b0}}, count_ff};

   assign status.out_free = !out_valid_ff || rsp_ready;

   // command decode: new count, cursor, error and the shift to apply
   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      err_in    = err_ff;
      do_ins    = 1'b0;
      do_rem    = 1'b0;
      pos       = cursor_ff;
      if (cmd.exec) begin
         err_in = 1'b0;
         case (kind_ff)
            KIND_START: begin
               cursor_in = '0;
            end
            KIND_ADVANCE: begin
               if (cur) cursor_in = cursor_ff + 1'b1;
               else     err_in    = 1'b1;
            end
            KIND_INSERT: begin
               if (full) begin
                  err_in = 1'b1;
               end else begin
                  pos       = cur ? cursor_ff : '0;
                  cursor_in = pos;
                  count_in  = count_ff + 1'b1;
                  do_ins    = 1'b1;
               end
            end
            KIND_ATTACH: begin
               if (full) begin
                  err_in = 1'b1;
               end else begin
                  pos       = cur ? cursor_ff + 1'b1 : count_ff;
                  cursor_in = pos;
                  count_in  = count_ff + 1'b1;
                  do_ins    = 1'b1;
               end
            end
            KIND_REMOVE: begin
               if (cur) begin
                  count_in = count_ff - 1'b1;
                  do_rem   = 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase
      end
   end

   // cell array: all cells from the insert or remove position shift at once
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         word_ff <= word_ext[ITEM_WIDTH-1:0];
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (do_ins) begin
            if (CW'(i) == pos) begin
               cells_ff[i] <= word_ff;
            end else if (i > 0) begin
               if (CW'(i) > pos) cells_ff[i] <= cells_ff[i-1];
            end
         end else if (do_rem) begin
            if (i < CAPACITY - 1) begin
               if (CW'(i) >= cursor_ff) cells_ff[i] <= cells_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
         err_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         err_ff    <= err_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.fetch) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         out_count_ff <= count_ext[COUNT_WIDTH-1:0];
         out_has_ff   <= cur;
         out_value_ff <= cur ? cell_ext[VALUE_WIDTH-1:0] : '0;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_item_count    = out_count_ff;
   assign rsp_has_current   = out_has_ff;
   assign rsp_current_value = out_value_ff;
   assign rsp_error         = out_err_ff;

endmodule

// File: design/cursor_ordered_list_engine.sv
// Ordered list of up to CAPACITY words with a cursor. Each command transfer on
// req_ch (start, advance, insert before, attach after, remove current) yields
// exactly one response transfer on rsp_ch with the item count, whether the
// cursor sits on an item, that item (zero when none), and an error bit for a
// refused command (full list, no current item, or an unused code); a refused
// command changes nothing. Words are stored in a register array that shifts
// all cells at once, so a command has an apply step, which shifts the cells
// and updates count and cursor, and a fetch step, which reads the item under
// the cursor into the response register. The next command is taken in the
// fetch step, in the cycle that loads the response register, so a new command
// overlaps the previous one's fetch but never its apply step; a stalled
// response holds the next command in the fetch step. Cell contents are not
// reset; only count, cursor, error flag and response valid flag are.
module cursor_ordered_list_engine import cole_pkg::*; #(
   parameter int CAPACITY   = 32,
   parameter int ITEM_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   cole_req_if.sink   req_ch,
   cole_rsp_if.source rsp_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: idle / apply / fetch
   cole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // cell array, count, cursor and response register
   cole_dp #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_ch.kind),
      .req_value         (req_ch.value),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_item_count    (rsp_ch.item_count),
      .rsp_has_current   (rsp_ch.has_current),
      .rsp_current_value (rsp_ch.current_value),
      .rsp_error         (rsp_ch.error)
   );

   // one command in flight: no transfer right after a command transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("command taken while previous one still being applied");

   // no current item means a zero item word in the response
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.has_current) |-> (rsp_ch.current_value == '0))
      else $error("item word nonzero without a current item");

   // a current item implies a nonempty list
   assert property (@(posedge clock) disable iff (reset)
      (CAPACITY < 64 && rsp_ch.valid && rsp_ch.has_current)
         |-> (rsp_ch.item_count != '0))
      else $error("current item reported on an empty list");

   // a response is only loaded once the previous one has been transferred
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready || !$past(req_ch.ready)
         || $past(req_ch.valid && req_ch.ready, 2) == 1'b0)
      else $error("response overwritten before transfer");

endmodule
